// File: sv/tdc_pkg.sv
// Shared types and constants for the 64x32 tile detile copy generator.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package tdc_pkg;

    localparam int ADDR_BITS_DEF = 32;
    localparam int CFG_ADDR_W    = 4;
    localparam int CFG_DATA_W    = 32;
    localparam int MUL_W         = 16;

    localparam int TILE_W_SHIFT  = 6;     // 64 bytes per tile line
    localparam int TILE_H_SHIFT  = 5;     // 32 lines per tile
    localparam int TILE_SHIFT    = 11;    // 2048 bytes per tile
    localparam int HALF_TILE     = 1024;  // chroma lower half

    localparam logic [13:0] WIDTH_RST  = 14'd1920;
    localparam logic [13:0] HEIGHT_RST = 14'd1088;
    localparam logic [14:0] STRIDE_RST = 15'd1920;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_STRIDE = 2'd2
    } t_reg_idx;

    typedef enum logic {
        PLANE_LUMA   = 1'b0,
        PLANE_CHROMA = 1'b1
    } t_plane;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GEOM,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_MUL4,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [13:0] width;
        logic [13:0] height;
        logic [14:0] stride;
    } t_cfg;

    typedef struct packed {
        t_plane      plane;
        logic [31:0] src_offset;
        logic [31:0] dst_offset;
        logic [6:0]  copy_len;
        logic        last;
    } t_cmd;

endpackage

// File: sv/tile64x32_detile_copy_generator_top.sv
// Top level of the 64x32 tile detile copy generator.
// Depends on tdc_pkg, tdc_cfg, tdc_mul, tdc_seq.
`timescale 1ns / 1ps

// Each request names one 64x32 tile of a Z-ordered, tile-paired NV12 frame
// and yields the line copy commands that move it into linear luma and
// interleaved chroma planes: per line pair two luma copies then one chroma
// copy, tlast on the final chroma copy. A tile outside the grid, or with
// fewer than two lines, yields nothing and frees the input after the
// geometry state. Otherwise setup runs geometry, then four products through
// one shared 16x16 multiplier, then the commands go out, pausing while the
// output stalls; the input is held until the last command is issued.
// The last command sits in the output register while the next tile starts.
// Offsets wrap at ADDR_BITS and are reported in 32 bits.
module tile64x32_detile_copy_generator_top
    import tdc_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [15:0]           i_s_axis_tdata,   // tile_col, tile_row
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [71:0]           o_m_axis_tdata,   // src_offset, dst_offset, copy_len
    output logic [0:0]            o_m_axis_tuser,   // plane
    output logic                  o_m_axis_tlast
);

    t_cfg               w_cfg;
    t_cmd               w_cmd;
    logic [MUL_W-1:0]   w_mul_a, w_mul_b;
    logic [2*MUL_W-1:0] w_mul_p;

    tdc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tdc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    tdc_seq #(
        .ADDR_BITS (ADDR_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_col       (i_s_axis_tdata[6:0]),
        .i_row       (i_s_axis_tdata[14:7]),
        .o_mul_a     (w_mul_a),
        .o_mul_b     (w_mul_b),
        .i_mul_p     (w_mul_p),
        .o_cmd       (w_cmd),
        .o_cmd_valid (o_m_axis_tvalid),
        .i_cmd_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {1'b0, w_cmd.copy_len, w_cmd.dst_offset, w_cmd.src_offset};
    assign o_m_axis_tuser = w_cmd.plane;
    assign o_m_axis_tlast = w_cmd.last;

`ifndef SYNTHESIS
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready right after a request");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[70:64] != 7'd0 && o_m_axis_tdata[70:64] <= 7'd64))
        else $error("copy length out of range");

    a_last_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> !o_m_axis_tlast)
        else $error("tlast on a luma copy");

    a_hold_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata)
            && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("command changed while stalled");
`endif

endmodule

// File: sv/tdc_cfg.sv
// APB-style register file: frame width, frame height, line stride.
// Depends on tdc_pkg.
`timescale 1ns / 1ps

module tdc_cfg
    import tdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= WIDTH_RST;
            r_cfg.height <= HEIGHT_RST;
            r_cfg.stride <= STRIDE_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_WIDTH:  r_cfg.width  <= pwdata[13:0];
                REG_HEIGHT: r_cfg.height <= pwdata[13:0];
                REG_STRIDE: r_cfg.stride <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_WIDTH:  prdata = CFG_DATA_W'(r_cfg.width);
            REG_HEIGHT: prdata = CFG_DATA_W'(r_cfg.height);
            REG_STRIDE: prdata = CFG_DATA_W'(r_cfg.stride);
            default:    prdata = '0;
        endcase
    end

endmodule

// File: sv/tdc_mul.sv
// Shared 16x16 multiplier with a registered product.
// Depends on tdc_pkg.
`timescale 1ns / 1ps

module tdc_mul
    import tdc_pkg::*;
(
    input  logic                 i_clk,
    input  logic [MUL_W-1:0]     i_a,
    input  logic [MUL_W-1:0]     i_b,
    output logic [2*MUL_W-1:0]   o_p
);

    logic [2*MUL_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// File: sv/tdc_seq.sv
// Sequencer: tile geometry, offset setup on the shared multiplier,
// then one copy command per cycle into the output register, unless stalled.
// Depends on tdc_pkg; drives tdc_mul.
`timescale 1ns / 1ps

module tdc_seq
    import tdc_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [6:0]         i_col,
    input  logic [7:0]         i_row,
    output logic [MUL_W-1:0]   o_mul_a,
    output logic [MUL_W-1:0]   o_mul_b,
    input  logic [2*MUL_W-1:0] i_mul_p,
    output t_cmd               o_cmd,
    output logic               o_cmd_valid,
    input  logic               i_cmd_ready
);

    localparam logic [1:0] PH_LUMA0  = 2'd0;
    localparam logic [1:0] PH_LUMA1  = 2'd1;
    localparam logic [1:0] PH_CHROMA = 2'd2;

    // Z-order skew of a tile inside its tile pair
    function automatic logic [8:0] pair_adj(input logic [6:0] col, input logic [7:0] row,
                                            input logic [9:0] rows);
        logic [8:0] res;
        res = '0;
        if (row[0]) begin
            res = 9'({col[6:2], 2'b00}) + 9'd2;
        end else if (!rows[0] || (10'(row) + 10'd1 != rows)) begin
            res = (9'(col) + 9'd2) & ~9'd3;
        end
        return res;
    endfunction

    t_state r_state, n_state;

    logic [6:0]           r_col;
    logic [7:0]           r_row;
    logic [8:0]           r_cols_even;
    logic [9:0]           r_rows_luma;
    logic [8:0]           r_rows_chroma;
    logic [6:0]           r_len;
    logic [4:0]           r_pairs;
    logic [4:0]           r_pair;
    logic [1:0]           r_phase;
    logic [ADDR_BITS-1:0] r_chroma_base;
    logic [ADDR_BITS-1:0] r_src_l, r_src_c, r_dst_l, r_dst_c;
    t_cmd                 r_cmd;
    logic                 r_cmd_valid;

    logic [8:0]  w_cols;
    logic [8:0]  w_cols_even;
    logic [9:0]  w_rows_luma;
    logic [8:0]  w_rows_chroma;
    logic [13:0] w_rem_w, w_rem_h;
    logic [5:0]  w_lines;
    logic        w_skip;
    logic        w_fire;
    logic        w_last;
    logic [8:0]  w_adj_l, w_adj_c;

    assign w_cols        = 9'((15'(i_cfg.width) + 15'd63) >> TILE_W_SHIFT);
    assign w_cols_even   = (w_cols + 9'd1) & ~9'd1;
    assign w_rows_luma   = 10'((15'(i_cfg.height) + 15'd31) >> TILE_H_SHIFT);
    assign w_rows_chroma = 9'((14'(i_cfg.height >> 1) + 14'd31) >> TILE_H_SHIFT);
    assign w_rem_w       = i_cfg.width - 14'({r_col, 6'b0});
    assign w_rem_h       = i_cfg.height - 14'({r_row, 5'b0});
    assign w_lines       = (w_rem_h > 14'd32) ? 6'd32 : w_rem_h[5:0];
    assign w_skip        = (9'(r_col) >= w_cols) || (10'(r_row) >= w_rows_luma)
                           || (w_lines[5:1] == 5'd0);

    assign w_adj_l = pair_adj(r_col, r_row, r_rows_luma);
    assign w_adj_c = pair_adj(r_col, 8'(r_row[7:1]), 10'(r_rows_chroma));

    assign w_last = (r_phase == PH_CHROMA) && (r_pair + 5'd1 == r_pairs);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_GEOM;
            S_GEOM: n_state = w_skip ? S_IDLE : S_MUL0;
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_MUL3;
            S_MUL3: n_state = S_MUL4;
            S_MUL4: n_state = S_EMIT;
            S_EMIT: if (w_fire && w_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_mul_a    = '0;
        o_mul_b    = '0;
        w_fire     = 1'b0;
        unique case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_MUL0: begin
                o_mul_a = MUL_W'(r_cols_even);
                o_mul_b = MUL_W'(r_rows_luma);
            end
            S_MUL1: begin
                o_mul_a = MUL_W'({r_row[7:1], 1'b0});
                o_mul_b = MUL_W'(r_cols_even);
            end
            S_MUL2: begin
                o_mul_a = MUL_W'({r_row[7:2], 1'b0});
                o_mul_b = MUL_W'(r_cols_even);
            end
            S_MUL3: begin
                o_mul_a = MUL_W'(r_row);
                o_mul_b = MUL_W'(i_cfg.stride);
            end
            S_EMIT: w_fire = !r_cmd_valid || i_cmd_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmd_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_cmd_valid <= 1'b1;
            end else if (i_cmd_ready) begin
                r_cmd_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_col <= i_col;
                r_row <= i_row;
            end
            S_GEOM: begin
                r_cols_even   <= w_cols_even;
                r_rows_luma   <= w_rows_luma;
                r_rows_chroma <= w_rows_chroma;
                r_len         <= (w_rem_w > 14'd64) ? 7'd64 : w_rem_w[6:0];
                r_pairs       <= w_lines[5:1];
                r_pair        <= '0;
                r_phase       <= PH_LUMA0;
            end
            S_MUL1: begin
                r_chroma_base <= ((ADDR_BITS'(i_mul_p) + ADDR_BITS'(3)) & ~ADDR_BITS'(3))
                                 << TILE_SHIFT;
            end
            S_MUL2: begin
                r_src_l <= (ADDR_BITS'(i_mul_p) + ADDR_BITS'(r_col) + ADDR_BITS'(w_adj_l))
                           << TILE_SHIFT;
            end
            S_MUL3: begin
                r_src_c <= r_chroma_base
                           + ((ADDR_BITS'(i_mul_p) + ADDR_BITS'(r_col)
                               + ADDR_BITS'(w_adj_c)) << TILE_SHIFT)
                           + (r_row[0] ? ADDR_BITS'(HALF_TILE) : '0);
            end
            S_MUL4: begin
                r_dst_l <= (ADDR_BITS'(i_mul_p) << TILE_H_SHIFT) + ADDR_BITS'({r_col, 6'b0});
                r_dst_c <= (ADDR_BITS'(i_mul_p) << (TILE_H_SHIFT - 1))
                           + ADDR_BITS'({r_col, 6'b0});
            end
            S_EMIT: begin
                if (w_fire) begin
                    r_cmd.copy_len <= r_len;
                    r_cmd.last     <= w_last;
                    if (r_phase == PH_CHROMA) begin
                        r_cmd.plane      <= PLANE_CHROMA;
                        r_cmd.src_offset <= 32'(r_src_c);
                        r_cmd.dst_offset <= 32'(r_dst_c);
                        r_src_c          <= r_src_c + ADDR_BITS'(64);
                        r_dst_c          <= r_dst_c + ADDR_BITS'(i_cfg.stride);
                        r_pair           <= r_pair + 5'd1;
                        r_phase          <= PH_LUMA0;
                    end else begin
                        r_cmd.plane      <= PLANE_LUMA;
                        r_cmd.src_offset <= 32'(r_src_l);
                        r_cmd.dst_offset <= 32'(r_dst_l);
                        r_src_l          <= r_src_l + ADDR_BITS'(64);
                        r_dst_l          <= r_dst_l + ADDR_BITS'(i_cfg.stride);
                        r_phase          <= (r_phase == PH_LUMA0) ? PH_LUMA1 : PH_CHROMA;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_cmd       = r_cmd;
    assign o_cmd_valid = r_cmd_valid;

endmodule
